>>> design/tsr_pkg.sv
// Shared types, constants and codes of the transport segment reassembler.
`timescale 1ns / 1ps

package tsr_pkg;

    // Sizes
    localparam int FRAG_SIZE       = 2048;
    localparam int MAX_SEG_PAYLOAD = 249;
    localparam int ADDR_W          = 11;   // fragment store address
    localparam int LEN_W           = 12;   // fragment byte count, 0..FRAG_SIZE
    localparam int SEQ_W           = 6;    // sequence number, modulo 64
    localparam int SEG_CNT_W       = 8;    // payload bytes of one segment, saturating
    localparam int STG_AW          = 9;    // staging memory: two banks of 256
    localparam int JOB_DEPTH       = 4;
    localparam int JOB_PW          = 2;
    localparam int OUT_DEPTH       = 4;
    localparam int OUT_PW          = 2;

    // Header bits
    localparam int HDR_FIN_BIT = 7;
    localparam int HDR_FIR_BIT = 6;

    // Opcodes
    localparam logic [1:0] OP_SEGMENT = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Status codes
    localparam logic [3:0] ST_ACCEPTED   = 4'd0;
    localparam logic [3:0] ST_COMPLETE   = 4'd1;
    localparam logic [3:0] ST_NO_PAYLOAD = 4'd2;
    localparam logic [3:0] ST_TOO_LONG   = 4'd3;
    localparam logic [3:0] ST_NO_FIR     = 4'd4;
    localparam logic [3:0] ST_BAD_LEN    = 4'd5;
    localparam logic [3:0] ST_BAD_SEQ    = 4'd6;
    localparam logic [3:0] ST_OVERFLOW   = 4'd7;
    localparam logic [3:0] ST_READ_REPLY = 4'd8;

    // Input item
    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        data_byte;
        logic              segment_start;
        logic              segment_end;
        logic [ADDR_W-1:0] read_index;
    } t_in;

    // Result item
    typedef struct packed {
        logic [3:0]       status;
        logic [LEN_W-1:0] fragment_length;
        logic             discarded_partial;
        logic [7:0]       read_data;
    } t_out;

    typedef enum logic {
        JOB_STATUS,
        JOB_READ
    } t_job_kind;

    // Work handed from the front end to the back end
    typedef struct packed {
        t_job_kind            kind;
        logic [3:0]           status;
        logic [LEN_W-1:0]     frag_len;
        logic                 disc;
        logic                 copy;      // move a staged payload into the store
        logic [ADDR_W-1:0]    base;
        logic [SEG_CNT_W-1:0] seg_len;
        logic                 bank;
        logic [ADDR_W-1:0]    read_index;
    } t_job;

    // Staging memory write from the front end
    typedef struct packed {
        logic              en;
        logic [STG_AW-1:0] addr;
        logic [7:0]        data;
    } t_stg_wr;

    // Staging bank release from the back end
    typedef struct packed {
        logic en;
        logic bank;
    } t_bank_rel;

endpackage

>>> design/tsr_front.sv
// Front end: takes items, stages payload bytes and applies the reassembly rules.
`timescale 1ns / 1ps

module tsr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsr_pkg::t_in      i_item,
    output logic              o_full,
    input  logic              i_q_full,
    output logic              o_job_push,
    output tsr_pkg::t_job     o_job,
    output tsr_pkg::t_stg_wr  o_stg_wr,
    input  tsr_pkg::t_bank_rel i_rel
);

    logic [tsr_pkg::LEN_W-1:0]     r_cc, n_cc;
    logic [tsr_pkg::SEQ_W-1:0]     r_es, n_es;
    logic [tsr_pkg::SEG_CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]                    r_hdr, n_hdr;
    logic                          r_perr, n_perr;
    logic                          r_in_seg, n_in_seg;
    logic                          r_bank, n_bank;
    logic [1:0]                    r_busy, n_busy;

    logic accept;

    // Hold off while the job queue is full or the bank to fill is still being copied
    assign o_full = i_q_full || r_busy[r_bank];
    assign accept = i_push && !o_full;

    // Item decode and end-of-segment checks
    always_comb begin
        logic [7:0]                    cur_hdr;
        logic [tsr_pkg::SEG_CNT_W-1:0] cur_len;
        logic                          cur_perr;
        logic                          finish;
        logic                          fir;
        logic                          fin;
        logic [tsr_pkg::SEQ_W-1:0]     seq;
        logic [tsr_pkg::LEN_W-1:0]     tmp_cc;
        logic [tsr_pkg::SEQ_W-1:0]     tmp_es;
        logic                          go_on;
        logic [3:0]                    st;

        n_cc     = r_cc;
        n_es     = r_es;
        n_cnt    = r_cnt;
        n_hdr    = r_hdr;
        n_perr   = r_perr;
        n_in_seg = r_in_seg;
        n_bank   = r_bank;
        o_job_push = 1'b0;
        o_job      = '0;
        o_stg_wr   = '0;
        cur_hdr  = r_hdr;
        cur_len  = r_cnt;
        cur_perr = r_perr;
        finish   = 1'b0;
        fir      = 1'b0;
        fin      = 1'b0;
        seq      = '0;
        tmp_cc   = r_cc;
        tmp_es   = r_es;
        go_on    = 1'b0;
        st       = tsr_pkg::ST_ACCEPTED;

        if (accept) begin
            case (i_item.opcode)
                tsr_pkg::OP_READ: begin
                    o_job_push       = 1'b1;
                    o_job.kind       = tsr_pkg::JOB_READ;
                    o_job.read_index = i_item.read_index;
                end
                tsr_pkg::OP_RESET: begin
                    n_cc     = '0;
                    n_es     = '0;
                    n_cnt    = '0;
                    n_perr   = 1'b0;
                    n_in_seg = 1'b0;
                end
                tsr_pkg::OP_SEGMENT: begin
                    if (i_item.segment_start) begin
                        cur_hdr  = i_item.data_byte;
                        cur_len  = '0;
                        cur_perr = 1'b0;
                        n_hdr    = i_item.data_byte;
                        n_cnt    = '0;
                        n_perr   = 1'b0;
                        n_in_seg = 1'b1;
                        finish   = i_item.segment_end;
                    end else if (r_in_seg) begin
                        if (r_cnt < tsr_pkg::SEG_CNT_W'(tsr_pkg::MAX_SEG_PAYLOAD)) begin
                            o_stg_wr.en   = 1'b1;
                            o_stg_wr.addr = {r_bank, r_cnt};
                            o_stg_wr.data = i_item.data_byte;
                        end
                        cur_perr = r_perr ||
                                   (r_cnt >= tsr_pkg::SEG_CNT_W'(tsr_pkg::MAX_SEG_PAYLOAD));
                        cur_len  = (r_cnt == {tsr_pkg::SEG_CNT_W{1'b1}}) ? r_cnt
                                                                          : r_cnt + 1'b1;
                        n_cnt    = cur_len;
                        n_perr   = cur_perr;
                        finish   = i_item.segment_end;
                    end
                end
                default: begin
                end
            endcase
        end

        // Segment end: one status result, maybe a payload copy
        if (finish) begin
            n_in_seg   = 1'b0;
            o_job_push = 1'b1;
            o_job.kind = tsr_pkg::JOB_STATUS;
            fir = cur_hdr[tsr_pkg::HDR_FIR_BIT];
            fin = cur_hdr[tsr_pkg::HDR_FIN_BIT];
            seq = cur_hdr[tsr_pkg::SEQ_W-1:0];
            if (cur_perr) begin
                st = tsr_pkg::ST_TOO_LONG;
            end else if (cur_len == '0) begin
                st = tsr_pkg::ST_NO_PAYLOAD;
            end else begin
                go_on = 1'b1;
                if (fir) begin
                    tmp_es = seq;
                    if (r_cc != '0) begin
                        o_job.disc = 1'b1;
                        tmp_cc     = '0;
                    end
                end else if (r_cc == '0) begin
                    st    = tsr_pkg::ST_NO_FIR;
                    go_on = 1'b0;
                end
                if (go_on) begin
                    if (!fin && cur_len != tsr_pkg::SEG_CNT_W'(tsr_pkg::MAX_SEG_PAYLOAD)) begin
                        st = tsr_pkg::ST_BAD_LEN;
                    end else if (seq != tmp_es) begin
                        st = tsr_pkg::ST_BAD_SEQ;
                    end else if (({1'b0, tmp_cc} + (tsr_pkg::LEN_W+1)'(cur_len)) >
                                 (tsr_pkg::LEN_W+1)'(tsr_pkg::FRAG_SIZE)) begin
                        tmp_cc = '0;
                        st     = tsr_pkg::ST_OVERFLOW;
                    end else begin
                        o_job.copy    = 1'b1;
                        o_job.base    = tmp_cc[tsr_pkg::ADDR_W-1:0];
                        o_job.seg_len = cur_len;
                        o_job.bank    = r_bank;
                        n_bank        = ~r_bank;
                        tmp_cc        = tmp_cc + tsr_pkg::LEN_W'(cur_len);
                        tmp_es        = tmp_es + 1'b1;
                        if (fin) begin
                            st             = tsr_pkg::ST_COMPLETE;
                            o_job.frag_len = tmp_cc;
                            tmp_cc         = '0;
                        end else begin
                            st = tsr_pkg::ST_ACCEPTED;
                        end
                    end
                end
                n_cc = tmp_cc;
                n_es = tmp_es;
            end
            o_job.status = st;
        end
    end

    // Bank busy flags: set when a copy is queued, cleared when the copy has read it all
    always_comb begin
        n_busy = r_busy;
        if (i_rel.en) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_job_push && o_job.copy) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc     <= '0;
            r_es     <= '0;
            r_cnt    <= '0;
            r_hdr    <= '0;
            r_perr   <= 1'b0;
            r_in_seg <= 1'b0;
            r_bank   <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_cc     <= n_cc;
            r_es     <= n_es;
            r_cnt    <= n_cnt;
            r_hdr    <= n_hdr;
            r_perr   <= n_perr;
            r_in_seg <= n_in_seg;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
        end
    end

endmodule

>>> design/tsr_job_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module tsr_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tsr_pkg::t_job o_job
);

    tsr_pkg::t_job              r_mem [tsr_pkg::JOB_DEPTH];
    logic [tsr_pkg::JOB_PW-1:0] r_wp, r_rp;
    logic [tsr_pkg::JOB_PW:0]   r_cnt;
    logic                       do_push, do_pop;

    assign o_full  = (r_cnt == (tsr_pkg::JOB_PW+1)'(tsr_pkg::JOB_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> design/tsr_back.sv
// Back end: staging banks, fragment store, payload copy engine and result queue.
`timescale 1ns / 1ps

module tsr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsr_pkg::t_stg_wr   i_stg_wr,
    input  logic               i_job_valid,
    input  tsr_pkg::t_job      i_job,
    output logic               o_job_pop,
    output tsr_pkg::t_bank_rel o_rel,
    output logic               o_empty,
    input  logic               i_pop,
    output tsr_pkg::t_out      o_result
);

    logic [7:0] r_stage [2**tsr_pkg::STG_AW];
    logic [7:0] r_store [tsr_pkg::FRAG_SIZE];

    // Copy engine
    logic                          r_cp_act;
    logic [tsr_pkg::SEG_CNT_W-1:0] r_cp_cnt, r_cp_len;
    logic [tsr_pkg::ADDR_W-1:0]    r_cp_base;
    logic                          r_cp_bank;
    logic                          r_wr_pend;
    logic [tsr_pkg::ADDR_W-1:0]    r_wr_addr;
    logic [7:0]                    r_stg_q;
    logic                          cp_last;

    // Read reply
    logic       r_rd_pend;
    logic [7:0] r_rd_q;

    // Result queue
    tsr_pkg::t_out              r_out [tsr_pkg::OUT_DEPTH];
    logic [tsr_pkg::OUT_PW-1:0] r_owp, r_orp;
    logic [tsr_pkg::OUT_PW:0]   r_ocnt;
    logic                       out_push, out_pop;
    tsr_pkg::t_out              out_data;

    logic take;

    // A job starts only once earlier copies and reads are finished and a result slot is free
    assign take = i_job_valid && !r_cp_act && !r_wr_pend && !r_rd_pend &&
                  (r_ocnt < (tsr_pkg::OUT_PW+1)'(tsr_pkg::OUT_DEPTH));
    assign o_job_pop = take;

    assign cp_last = r_cp_act && (r_cp_cnt == r_cp_len - 1'b1);
    assign o_rel   = '{en: cp_last, bank: r_cp_bank};

    // Staging banks: written by the front end, read by the copy engine
    always_ff @(posedge i_clk) begin
        if (i_stg_wr.en) begin
            r_stage[i_stg_wr.addr] <= i_stg_wr.data;
        end
        r_stg_q <= r_stage[{r_cp_bank, r_cp_cnt}];
    end

    // Fragment store: copy writes, read replies
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_store[r_wr_addr] <= r_stg_q;
        end
        r_rd_q <= r_store[i_job.read_index];
    end

    // Copy sequencer, one byte per cycle
    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_cp_base + tsr_pkg::ADDR_W'(r_cp_cnt);
        if (take && i_job.kind == tsr_pkg::JOB_STATUS && i_job.copy) begin
            r_cp_cnt  <= '0;
            r_cp_len  <= i_job.seg_len;
            r_cp_base <= i_job.base;
            r_cp_bank <= i_job.bank;
        end else if (r_cp_act) begin
            r_cp_cnt <= r_cp_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_act  <= 1'b0;
            r_wr_pend <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_wr_pend <= r_cp_act;
            r_rd_pend <= take && (i_job.kind == tsr_pkg::JOB_READ);
            if (take && i_job.kind == tsr_pkg::JOB_STATUS && i_job.copy) begin
                r_cp_act <= 1'b1;
            end else if (cp_last) begin
                r_cp_act <= 1'b0;
            end
        end
    end

    // Result assembly
    always_comb begin
        out_data = '0;
        if (r_rd_pend) begin
            out_data.status    = tsr_pkg::ST_READ_REPLY;
            out_data.read_data = r_rd_q;
        end else begin
            out_data.status            = i_job.status;
            out_data.fragment_length   = i_job.frag_len;
            out_data.discarded_partial = i_job.disc;
        end
    end

    assign out_push = r_rd_pend || (take && i_job.kind == tsr_pkg::JOB_STATUS);
    assign out_pop  = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_out[r_orp];

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out[r_owp] <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (out_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (out_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            case ({out_push, out_pop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

endmodule

>>> design/transport_segment_reassembler.sv
// Top level of the transport segment reassembler.
`timescale 1ns / 1ps

// Takes one item per transfer (segment byte, fragment read or reassembly reset) and gives
// at most one result per item, in order, through a four-entry result queue. Reads and
// segment ends pass a four-entry job queue. With the back end free, a segment's status is
// registered in the job queue and then in the result queue. A read reply passes the job
// queue, the store read register and the result queue. An accepted payload is staged in
// one of two 256-byte banks. The back end then copies it into the 2048-byte fragment store
// at one byte per cycle. A segment's copy holds the back end through its start, the
// copy of each payload byte and the last store write. A read waits behind any copy queued
// before it and holds the back end until its reply is queued. Any other status goes into
// the result queue as it is taken. full rises when the job queue is full or when the
// staging bank for the next segment is still being copied out, and it holds off every kind
// of item. Long runs of back-to-back full-size segments or back-to-back reads therefore
// see full raised now and then. The store needs no clearing pass after reset.
module transport_segment_reassembler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  tsr_pkg::t_in  i_item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output tsr_pkg::t_out o_result
);

    logic               q_full, q_push, q_pop, q_valid;
    tsr_pkg::t_job      q_in_job, q_out_job;
    tsr_pkg::t_stg_wr   stg_wr;
    tsr_pkg::t_bank_rel bank_rel;

    tsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_q_full   (q_full),
        .o_job_push (q_push),
        .o_job      (q_in_job),
        .o_stg_wr   (stg_wr),
        .i_rel      (bank_rel)
    );

    tsr_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    tsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stg_wr    (stg_wr),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_job_pop   (q_pop),
        .o_rel       (bank_rel),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

>>> design/tsr_checker.sv
// Port-level checks of the transport segment reassembler and their binding.
`timescale 1ns / 1ps

module tsr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          empty,
    input logic          pop,
    input tsr_pkg::t_out o_result
);

    // A waiting result holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed before transfer");

    // Read replies carry no length or discard flag
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == tsr_pkg::ST_READ_REPLY |->
            o_result.fragment_length == '0 && !o_result.discarded_partial)
        else $error("read reply with status fields set");

    // Only a completed fragment reports a length
    a_len_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status != tsr_pkg::ST_COMPLETE |->
            o_result.fragment_length == '0)
        else $error("length reported without fragment completion");

    // A completed fragment is never empty and never longer than the fragment store
    a_complete_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == tsr_pkg::ST_COMPLETE |->
            o_result.fragment_length != '0 &&
            o_result.fragment_length <= tsr_pkg::LEN_W'(tsr_pkg::FRAG_SIZE))
        else $error("completed fragment length out of range");

    // Data byte only on read replies
    a_data_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status != tsr_pkg::ST_READ_REPLY |->
            o_result.read_data == '0)
        else $error("read data on a status result");

endmodule

bind transport_segment_reassembler tsr_checker u_tsr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

>>> dv/tb_transport_segment_reassembler.sv
// Self-checking testbench of the transport segment reassembler: predicted results vs. DUT.
`timescale 1ns / 1ps

module tb_transport_segment_reassembler;
    import tsr_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1700;
    localparam int         IDLE_PCT     = 31;
    localparam int         DRAIN_CYCLES = 400;   // longest store copy plus margin

    // Ways a random fragment gets broken
    typedef enum int {
        FAULT_NONE,
        FAULT_SEQ,
        FAULT_SHORT,
        FAULT_FIR,
        FAULT_ABANDON,
        FAULT_EMPTY,
        FAULT_RESET,
        FAULT_OVERSIZE
    } t_fault;

    // Reassembly predictor and queue of expected status/read results
    class reassembly_scoreboard;
        logic [7:0] frag_bytes [FRAG_SIZE];
        logic [7:0] stage [MAX_SEG_PAYLOAD];
        int         committed;
        int         written_top;   // store entries [0, written_top) hold written data
        logic [5:0] next_seq;
        int         seg_bytes;
        logic [7:0] header;
        logic [3:0] held_err;
        logic       disc;
        bit         open_seg;
        t_out       expected_q[$];
        int         errors;

        function new();
            foreach (frag_bytes[i]) frag_bytes[i] = 8'h00;
            foreach (stage[i]) stage[i] = 8'h00;
            committed   = 0;
            written_top = 0;
            next_seq    = '0;
            seg_bytes   = 0;
            header      = '0;
            held_err    = '0;
            disc        = 1'b0;
            open_seg    = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Reassembly rules applied when a segment closes
        function logic [3:0] close_segment(output logic [LEN_W-1:0] frag_len);
            logic       fir;
            logic       fin;
            logic [5:0] seq;
            fir      = header[HDR_FIR_BIT];
            fin      = header[HDR_FIN_BIT];
            seq      = header[SEQ_W-1:0];
            frag_len = '0;
            open_seg = 1'b0;
            if (held_err != '0) return ST_TOO_LONG;
            if (seg_bytes == 0) return ST_NO_PAYLOAD;
            if (fir) begin
                next_seq = seq;
                if (committed > 0) begin
                    disc      = 1'b1;
                    committed = 0;
                end
            end else if (committed == 0) begin
                return ST_NO_FIR;
            end
            if (!fin && seg_bytes != MAX_SEG_PAYLOAD) return ST_BAD_LEN;
            if (seq != next_seq) return ST_BAD_SEQ;
            if (FRAG_SIZE - committed < seg_bytes) begin
                committed = 0;
                return ST_OVERFLOW;
            end
            for (int i = 0; i < seg_bytes; i++) frag_bytes[committed + i] = stage[i];
            committed += seg_bytes;
            if (committed > written_top) written_top = committed;
            next_seq = next_seq + 6'd1;
            if (fin) begin
                frag_len  = LEN_W'(committed);
                committed = 0;
                return ST_COMPLETE;
            end
            return ST_ACCEPTED;
        endfunction

        // Accepted input transfer; returns 1 when the item had any effect
        function bit note_input(t_in it);
            logic [3:0]       st;
            logic [LEN_W-1:0] len;
            t_out             res;
            res = '0;
            case (it.opcode)
                OP_READ: begin
                    res.status    = ST_READ_REPLY;
                    res.read_data = frag_bytes[it.read_index];
                    expected_q.push_back(res);
                    return 1'b1;
                end
                OP_RESET: begin
                    committed = 0;
                    next_seq  = '0;
                    seg_bytes = 0;
                    held_err  = '0;
                    open_seg  = 1'b0;
                    return 1'b1;
                end
                OP_SEGMENT: begin
                    if (it.segment_start) begin
                        header    = it.data_byte;
                        seg_bytes = 0;
                        held_err  = '0;
                        open_seg  = 1'b1;
                    end else begin
                        if (!open_seg) return 1'b0;   // stray byte
                        if (seg_bytes < MAX_SEG_PAYLOAD) stage[seg_bytes] = it.data_byte;
                        else held_err = ST_TOO_LONG;
                        if (seg_bytes < 255) seg_bytes++;
                    end
                    if (it.segment_end) begin
                        disc                  = 1'b0;
                        st                    = close_segment(len);
                        res.status            = st;
                        res.fragment_length   = len;
                        res.discarded_partial = disc;
                        expected_q.push_back(res);
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        // Accepted result transfer against the oldest expectation
        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.fragment_length !== want.fragment_length) begin
                $error("fragment_length expected %0d actual %0d",
                       want.fragment_length, got.fragment_length);
                errors++;
            end
            if (got.discarded_partial !== want.discarded_partial) begin
                $error("discarded_partial expected %0d actual %0d",
                       want.discarded_partial, got.discarded_partial);
                errors++;
            end
            if (got.read_data !== want.read_data) begin
                $error("read_data expected 0x%02h actual 0x%02h", want.read_data, got.read_data);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    t_in  i_item;
    logic full;
    logic empty;
    logic pop = 1'b0;
    t_out o_result;
    bit   steady = 1'b0;   // no idling on either side while set
    int   work_items = 0;

    reassembly_scoreboard sb;

    transport_segment_reassembler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: random pop, every transfer checked
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_result);
        pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input t_in it);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        if (sb.note_input(it)) work_items++;
    endtask

    // Hold off the sender until every expected result has come
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] seg_header(input logic fin, input logic fir,
                                              input logic [5:0] seq);
        logic [7:0] h;
        h              = {2'b00, seq};
        h[HDR_FIN_BIT] = fin;
        h[HDR_FIR_BIT] = fir;
        return h;
    endfunction

    task automatic send_op(input logic [1:0] op);
        t_in it;
        it.opcode        = op;
        it.data_byte     = 8'($urandom);
        it.segment_start = 1'($urandom);
        it.segment_end   = 1'($urandom);
        it.read_index    = ADDR_W'($urandom);
        send_item(it);
    endtask

    task automatic send_read(input int idx);
        t_in it;
        it.opcode        = OP_READ;
        it.data_byte     = 8'($urandom);
        it.segment_start = 1'($urandom);
        it.segment_end   = 1'($urandom);
        it.read_index    = ADDR_W'(idx);
        send_item(it);
    endtask

    // Read of an entry that already holds fragment data
    task automatic send_random_read();
        send_read($urandom_range(0, sb.written_top - 1));
    endtask

    task automatic seg_byte(input logic [7:0] data, input logic last);
        t_in it;
        it.opcode        = OP_SEGMENT;
        it.data_byte     = data;
        it.segment_start = 1'b0;
        it.segment_end   = last;
        it.read_index    = ADDR_W'($urandom);
        send_item(it);
    endtask

    // Header plus n random payload bytes; reads are slipped in now and then
    task automatic send_segment(input logic [7:0] hdr, input int n_bytes, input bit closed);
        t_in it;
        it.opcode        = OP_SEGMENT;
        it.data_byte     = hdr;
        it.segment_start = 1'b1;
        it.segment_end   = closed && (n_bytes == 0);
        it.read_index    = ADDR_W'($urandom);
        send_item(it);
        for (int i = 0; i < n_bytes; i++) begin
            if (sb.written_top > 0 && $urandom_range(0, 99) < 2) send_random_read();
            seg_byte(8'($urandom), closed && (i == n_bytes - 1));
        end
    endtask

    // n_full full non-FIN segments then a FIN segment, with an optional fault
    task automatic send_fragment(input int n_full, input int last_len, input t_fault fault,
                                 input int fault_at);
        logic [5:0] seq;
        logic       fir;
        logic       fin;
        int         len;
        seq = 6'($urandom);
        for (int s = 0; s <= n_full; s++) begin
            fin = (s == n_full);
            fir = (s == 0);
            len = fin ? last_len : MAX_SEG_PAYLOAD;
            if (s > 0) seq = sb.next_seq;
            if (s == fault_at) begin
                case (fault)
                    FAULT_SEQ:      seq = seq + 6'($urandom_range(1, 63));
                    FAULT_SHORT:    len = $urandom_range(1, MAX_SEG_PAYLOAD - 1);
                    FAULT_FIR:      fir = !fir;
                    FAULT_ABANDON:  send_segment(8'($urandom), $urandom_range(0, 20), 1'b0);
                    FAULT_EMPTY:    len = 0;
                    FAULT_RESET:    send_op(OP_RESET);
                    FAULT_OVERSIZE: len = $urandom_range(MAX_SEG_PAYLOAD + 1, 300);
                    default: ;
                endcase
            end
            send_segment(seg_header(fin, fir, seq), len, 1'b1);
        end
    endtask

    // Mostly short well-formed fragments, some multi-segment, about 30% broken
    task automatic random_fragment();
        int     r;
        int     n_full;
        int     last_len;
        t_fault fault;
        r        = $urandom_range(0, 99);
        n_full   = (r < 80) ? 0 : (r < 95) ? 1 : 2;
        last_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_SEG_PAYLOAD)
                                               : $urandom_range(1, 20);
        fault    = ($urandom_range(0, 99) < 70) ? FAULT_NONE
                                                : t_fault'($urandom_range(1, FAULT_OVERSIZE));
        send_fragment(n_full, last_len, fault, $urandom_range(0, n_full));
    endtask

    // Any field values; reads kept to written entries
    task automatic send_noise();
        t_in it;
        it.opcode        = 2'($urandom_range(0, 3));
        it.data_byte     = 8'($urandom);
        it.segment_start = 1'($urandom);
        it.segment_end   = 1'($urandom);
        it.read_index    = ADDR_W'($urandom);
        if (it.opcode == OP_READ) begin
            if (sb.written_top == 0) it.opcode = OP_SEGMENT;
            else it.read_index = ADDR_W'($urandom_range(0, sb.written_top - 1));
        end
        send_item(it);
    endtask

    // Stimulus
    initial begin
        int r;
        sb = new();
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: header only, no FIR, payload extremes, reads, bad length,
        // stray byte, unused opcode, abandoned segment, reset opcode
        send_segment(seg_header(1'b1, 1'b1, 6'd0), 0, 1'b1);
        send_segment(seg_header(1'b1, 1'b0, 6'd0), 2, 1'b1);
        send_segment(seg_header(1'b1, 1'b1, 6'd5), 0, 1'b0);
        seg_byte(8'h00, 1'b0);
        seg_byte(8'hFF, 1'b0);
        seg_byte(8'hA5, 1'b1);
        send_read(0);
        send_read(2);
        send_segment(seg_header(1'b0, 1'b1, 6'd9), 2, 1'b1);
        seg_byte(8'h3C, 1'b1);
        send_op(OP_UNUSED);
        send_segment(seg_header(1'b0, 1'b1, 6'd63), 1, 1'b0);
        send_segment(seg_header(1'b1, 1'b1, 6'd63), 1, 1'b1);
        send_op(OP_RESET);
        send_segment(seg_header(1'b1, 1'b0, 6'd0), 3, 1'b1);
        wait_drained();

        // Long stretch without idling: oversize segment, a full 2048-byte
        // fragment, store overflow, bad sequence, FIR discarding a partial
        steady = 1'b1;
        send_fragment(0, 260, FAULT_NONE, 0);
        send_fragment(8, FRAG_SIZE - 8 * MAX_SEG_PAYLOAD, FAULT_NONE, 0);
        send_read(FRAG_SIZE - 1);
        send_read(0);
        send_fragment(8, FRAG_SIZE - 8 * MAX_SEG_PAYLOAD + 4, FAULT_NONE, 0);
        send_segment(seg_header(1'b1, 1'b0, sb.next_seq), 4, 1'b1);
        send_fragment(1, 5, FAULT_SEQ, 1);
        send_fragment(0, 5, FAULT_NONE, 0);
        steady = 1'b0;
        wait_drained();

        // Random traffic
        work_items = 0;
        while (work_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55 || (r < 75 && sb.written_top == 0)) begin
                random_fragment();
            end else if (r < 75) begin
                repeat ($urandom_range(1, 4)) send_random_read();
            end else if (r < 87) begin
                send_noise();
            end else if (r < 92) begin
                seg_byte(8'($urandom), 1'($urandom));
            end else if (r < 95) begin
                send_op(OP_UNUSED);
            end else if (r < 98) begin
                send_op(OP_RESET);
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
